@@ rtl/core/cascaded_biquad_filter_unit_assert.svh @@
// Assertion macros shared by the filter RTL.
`ifndef CASCADED_BIQUAD_FILTER_UNIT_ASSERT_SVH
`define CASCADED_BIQUAD_FILTER_UNIT_ASSERT_SVH

// Checks that an implication holds at every clock edge outside reset.
`define CBF_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a condition holds in the cycle after another one holds.
`define CBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cbf_pkg.sv @@
`default_nettype none
package cbf_pkg;
    localparam int unsigned NumCoef   = 5;
    localparam int unsigned SampleW   = 16;
    localparam int unsigned CoefW     = 32;
    localparam int unsigned ResidW    = 14;
    localparam int unsigned ProdW     = CoefW + SampleW;

    localparam logic [2:0] SlotB0 = 3'd0;
    localparam logic [2:0] SlotB1 = 3'd1;
    localparam logic [2:0] SlotB2 = 3'd2;
    localparam logic [2:0] SlotA1 = 3'd3;
    localparam logic [2:0] SlotA2 = 3'd4;

    localparam logic ActFilter = 1'b0;
    localparam logic ActWrite  = 1'b1;

    localparam logic [CoefW-1:0] UnityGain = 32'h4000_0000;

    // Command from the sequencer to the serial multiplier.
    typedef struct packed {
        logic                     start;
        logic signed [CoefW-1:0]  coef;
        logic signed [SampleW-1:0] data;
    } t_mul_cmd;

    // Saturate a 32-bit accumulator shifted right by 14 to 16 bits.
    function automatic logic signed [SampleW-1:0] sat_shift(input logic [CoefW-1:0] acc);
        logic signed [CoefW-ResidW-1:0] q;
        q = $signed(acc[CoefW-1:ResidW]);
        if (q > $signed(18'sd32767)) begin
            return 16'sh7fff;
        end else if (q < -$signed(18'sd32768)) begin
            return 16'sh8000;
        end else begin
            return q[SampleW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/cbf_mul.sv @@
`default_nettype none
// Shift-add multiplier: one bit of the 16-bit sample per cycle.
// Returns floor(coef * data / 2^16) truncated to 32 bits.
module cbf_mul (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire cbf_pkg::t_mul_cmd        i_cmd,
    output logic                          o_done,
    output logic [cbf_pkg::CoefW-1:0]     o_prod
);
    import cbf_pkg::*;

    logic signed [ProdW-1:0] r_acc, n_acc;
    logic [SampleW-1:0]      r_mplr, n_mplr;
    logic signed [CoefW-1:0] r_mcnd, n_mcnd;
    logic [4:0]              r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic signed [ProdW-1:0] w_pp;

    // Partial product of the current multiplier bit; the sign bit weighs negative.
    always_comb begin
        w_pp = r_mplr[0] ? (ProdW'(r_mcnd) <<< r_cnt[3:0]) : '0;
        n_acc  = r_acc;
        n_mplr = r_mplr;
        n_mcnd = r_mcnd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_acc  = '0;
            n_mplr = i_cmd.data;
            n_mcnd = i_cmd.coef;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc  = (r_cnt == 5'(SampleW - 1)) ? r_acc - w_pp : r_acc + w_pp;
            n_mplr = r_mplr >> 1;
            n_cnt  = r_cnt + 5'd1;
            if (r_cnt == 5'(SampleW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc  <= n_acc;
        r_mplr <= n_mplr;
        r_mcnd <= n_mcnd;
    end

    assign o_done = r_done;
    assign o_prod = r_acc[ProdW-1:SampleW];
endmodule
`default_nettype wire

@@ rtl/core/cascaded_biquad_filter_unit.sv @@
`default_nettype none
// Cascade of up to MAX_STAGES direct-form-1 biquads on signed 16-bit samples.
// Input tdata carries sample, stage_index, coef_slot and coef_value from the
// lowest bit up, tuser the action (0 filter, 1 coefficient write). A write
// produces no output. A filter transfer runs, for each product, a
// coefficient fetch, a multiplier start and the sixteen shift-add steps
// with the done flag, five products and one history update per enabled
// stage; the single bit-serial multiplier serves every product. After the
// last stage the result is loaded into the output register once that
// register is free, and the next transfer can be taken in the cycle after
// the load. A result still waiting at the output does not block the
// input; only a finished result that cannot be loaded holds the sequencer.
// After reset the coefficient memory is cleared, b0 of the first stage set
// to unity gain, while the input is not ready.
// Output tdata holds the filtered sample. Coefficient a1 and a2 are
// negated on write.
`include "cascaded_biquad_filter_unit_assert.svh"
module cascaded_biquad_filter_unit #(
    parameter int unsigned MAX_STAGES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // sample, stage_index, coef_slot, coef_value
    input  wire logic        s_axis_tuser,  // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // filtered
);
    import cbf_pkg::*;

    localparam int unsigned StW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int unsigned CntW  = $clog2(MAX_STAGES + 1);
    localparam int unsigned Depth = NumCoef * MAX_STAGES;
    localparam int unsigned AddrW = $clog2(Depth);

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_MUL, S_WAIT, S_ACC, S_OUT} t_state;

    // Coefficient memory, one write port and one registered read port.
    logic [CoefW-1:0] r_coef_mem [Depth];
    logic [CoefW-1:0] r_coef_rd;
    logic             r_init;
    logic [AddrW-1:0] r_init_addr;

    logic signed [SampleW-1:0] r_xh0 [MAX_STAGES];
    logic signed [SampleW-1:0] r_xh1 [MAX_STAGES];
    logic signed [SampleW-1:0] r_yh0 [MAX_STAGES];
    logic signed [SampleW-1:0] r_yh1 [MAX_STAGES];
    logic [ResidW-1:0]         r_resid [MAX_STAGES];
    logic [CntW-1:0]           r_used;

    t_state                    r_state;
    logic [StW-1:0]            r_stage;
    logic [2:0]                r_slot;
    logic [CoefW-1:0]          r_acc;
    logic signed [SampleW-1:0] r_x;
    logic signed [SampleW-1:0] r_out;
    logic                      r_ovalid;

    t_mul_cmd                  w_cmd;
    logic                      w_mdone;
    logic [CoefW-1:0]          w_prod;
    logic [AddrW-1:0]          w_raddr;
    logic signed [SampleW-1:0] w_opnd;
    logic signed [SampleW-1:0] w_y;
    logic [CoefW-1:0]          w_sum;
    logic                      w_acc_in;
    logic [2:0]                w_in_stage;
    logic [2:0]                w_in_slot;
    logic [CoefW-1:0]          w_in_val;
    logic [CoefW-1:0]          w_wval;
    logic                      w_wr_ok;

    assign w_in_stage = s_axis_tdata[18:16];
    assign w_in_slot  = s_axis_tdata[21:19];
    assign w_in_val   = s_axis_tdata[53:22];
    assign w_wr_ok    = (32'(w_in_stage) < MAX_STAGES) && (w_in_slot <= SlotA2);
    assign w_wval     = (w_in_slot >= SlotA1) ? (32'd0 - w_in_val) : w_in_val;

    assign s_axis_tready = (r_state == S_IDLE) && !r_init;
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;

    assign w_raddr = AddrW'(32'(r_stage) * NumCoef + 32'(r_slot));

    // Operand of the current product.
    always_comb begin
        case (r_slot)
            SlotB0:  w_opnd = r_x;
            SlotB1:  w_opnd = r_xh0[r_stage];
            SlotB2:  w_opnd = r_xh1[r_stage];
            SlotA1:  w_opnd = r_yh0[r_stage];
            SlotA2:  w_opnd = r_yh1[r_stage];
            default: w_opnd = '0;
        endcase
    end

    assign w_cmd.start = (r_state == S_MUL);
    assign w_cmd.coef  = r_coef_rd;
    assign w_cmd.data  = w_opnd;
    assign w_sum       = r_acc + w_prod;
    assign w_y         = sat_shift(r_acc);

    cbf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    // Coefficient memory: reset fill sweep, write transfers, sequencer reads.
    always_ff @(posedge i_clk) begin
        if (r_init) begin
            r_coef_mem[r_init_addr] <= (r_init_addr == '0) ? UnityGain : '0;
        end else if (w_acc_in && s_axis_tuser == ActWrite && w_wr_ok) begin
            r_coef_mem[AddrW'(32'(w_in_stage) * NumCoef + 32'(w_in_slot))] <= w_wval;
        end
        r_coef_rd <= r_coef_mem[w_raddr];
    end

    // Sequencer and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b1;
            r_init_addr <= '0;
            r_used      <= CntW'(1);
            r_ovalid    <= 1'b0;
            r_stage     <= '0;
            r_slot      <= SlotB0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_xh0[i]   <= '0;
                r_xh1[i]   <= '0;
                r_yh0[i]   <= '0;
                r_yh1[i]   <= '0;
                r_resid[i] <= '0;
            end
        end else begin
            if (r_init) begin
                r_init_addr <= r_init_addr + AddrW'(1);
                if (32'(r_init_addr) == Depth - 1) begin
                    r_init <= 1'b0;
                end
            end
            // Output register: load a finished result, or empty it on a transfer.
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (s_axis_tuser == ActWrite) begin
                            if (w_wr_ok) begin
                                r_resid[w_in_stage[StW-1:0]] <= '0;
                                if (32'(r_used) < 32'(w_in_stage) + 1) begin
                                    r_used <= CntW'(32'(w_in_stage) + 1);
                                end
                            end
                        end else begin
                            r_x     <= $signed(s_axis_tdata[15:0]);
                            r_stage <= '0;
                            r_slot  <= SlotB0;
                            r_acc   <= 32'(r_resid[0]);
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: r_state <= S_MUL;
                S_MUL:   r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_mdone) begin
                        r_acc <= w_sum;
                        if (r_slot == SlotA2) begin
                            r_state <= S_ACC;
                        end else begin
                            r_slot  <= r_slot + 3'd1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_ACC: begin
                    r_resid[r_stage] <= r_acc[ResidW-1:0];
                    r_xh1[r_stage]   <= r_xh0[r_stage];
                    r_xh0[r_stage]   <= r_x;
                    r_yh1[r_stage]   <= r_yh0[r_stage];
                    r_yh0[r_stage]   <= w_y;
                    r_x              <= w_y;
                    r_slot           <= SlotB0;
                    if (32'(r_stage) + 1 >= 32'(r_used)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_stage <= r_stage + StW'(1);
                        r_acc   <= 32'(r_resid[r_stage + StW'(1)]);
                        r_state <= S_FETCH;
                    end
                end
                S_OUT: begin
                    // Wait here while an earlier result still occupies the output.
                    if (!r_ovalid || m_axis_tready) begin
                        r_out   <= r_x;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    `CBF_ASSERT_IMPL(a_idle_acc, i_clk, i_rst_n, !w_acc_in || r_state == S_IDLE, "busy accept")
    `CBF_ASSERT_IMPL(a_used, i_clk, i_rst_n, r_used != '0 && 32'(r_used) <= MAX_STAGES, "bad count")
    `CBF_ASSERT_NEXT(a_out_vld, i_clk, i_rst_n, r_state == S_OUT, r_ovalid, "no result")
    `CBF_ASSERT_NEXT(a_mul_wait, i_clk, i_rst_n, r_state == S_MUL, r_state == S_WAIT, "no start")
endmodule
`default_nettype wire
